// ----- hdl/jsrr_pkg.sv -----
// Shared constants for the job slot table with round-robin pickup.
// Used by jsrr_store and job_slot_table_round_robin; depends on nothing.

package jsrr_pkg;

  // Table geometry
  localparam int unsigned SLOTS    = 32;
  localparam int unsigned JOB_BITS = 64;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);

  // Stream field widths
  localparam int unsigned JOB_W    = 64;
  localparam int unsigned PEND_W   = 6;
  localparam int unsigned OUT_W    = 1 + JOB_W + 1 + PEND_W;

  // Command codes carried on the input tuser
  localparam logic CMD_DISPATCH = 1'b0;
  localparam logic CMD_SEARCH   = 1'b1;

endpackage

// ----- hdl/job_slot_table_round_robin.sv -----
// Top level of the job slot table with round-robin pickup.
// Depends on jsrr_pkg and instantiates jsrr_store.
//   Input beats arrive on the s_axis group: tuser selects dispatch (0) or
//   search (1), tdata carries the job word. Each beat yields exactly one
//   result beat on the m_axis group (found, job word, accepted, pending
//   job count).
//   A dispatch stores its job word in the lowest-numbered empty slot; a
//   search walks the slots round-robin from the one after the slot taken
//   last, frees the first busy slot and returns its job word.
//   A small sequencer tests one slot per cycle with a shared index
//   incrementer and busy-bit compare. An item stops at the k-th slot
//   examined (k = 1..32, or 32 on a full or empty table); a search that
//   hits passes through an extra read state since the job memory read is
//   registered. s_axis_tready is high only while the sequencer is idle, so
//   a new item is taken only once the last one has left the sequencer.
//   The result sits in an output register; the next item is taken while
//   it waits, and a stalled receiver only holds the sequencer once that
//   next item has finished. Reset empties every slot, clears the count and
//   sets the slot taken last to the highest slot, so the first search starts at slot 0.

module job_slot_table_round_robin (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: [63:0] job_in
  input  logic [jsrr_pkg::JOB_W-1:0]  s_axis_tdata,
  // tuser: [0] cmd
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: [0] found, [64:1] job_out, [65] accepted, [71:66] pending_jobs
  output logic [jsrr_pkg::OUT_W-1:0]  m_axis_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_e;

  state_e                            state_q;
  logic [jsrr_pkg::SLOT_W-1:0]       idx_q;
  logic [jsrr_pkg::SLOT_W-1:0]       steps_q;
  logic [jsrr_pkg::SLOT_W-1:0]       last_q;
  logic [jsrr_pkg::SLOTS-1:0]        busy_q;
  logic [jsrr_pkg::CNT_W-1:0]        count_q;
  logic                              cmd_q;
  logic [jsrr_pkg::JOB_BITS-1:0]     job_q;
  logic                              res_found_q;
  logic                              res_acc_q;
  logic                              out_valid_q;
  logic [jsrr_pkg::OUT_W-1:0]        out_data_q;

  logic                              hit;
  logic                              last_step;
  logic                              out_free;
  logic                              mem_we;
  logic                              mem_re;
  logic [jsrr_pkg::JOB_BITS-1:0]     mem_rdata;
  logic [jsrr_pkg::JOB_W-1:0]        job_out;

  // Step an index forward, wrapping at the slot count
  function automatic logic [jsrr_pkg::SLOT_W-1:0] next_slot(
    input logic [jsrr_pkg::SLOT_W-1:0] i
  );
    logic [jsrr_pkg::SLOT_W-1:0] r;
    if (i == jsrr_pkg::SLOT_W'(jsrr_pkg::SLOTS - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  // Shared slot test: empty slot for dispatch, busy slot for search
  always_comb begin
    if (cmd_q == jsrr_pkg::CMD_SEARCH) begin
      hit = busy_q[idx_q];
    end else begin
      hit = !busy_q[idx_q];
    end
  end

  assign last_step = (steps_q == jsrr_pkg::SLOT_W'(jsrr_pkg::SLOTS - 1));
  assign out_free  = !out_valid_q || m_axis_tready;
  assign mem_we    = (state_q == ST_SCAN) && hit && (cmd_q == jsrr_pkg::CMD_DISPATCH);
  assign mem_re    = (state_q == ST_SCAN) && hit && (cmd_q == jsrr_pkg::CMD_SEARCH);
  assign job_out   = res_found_q ? jsrr_pkg::JOB_W'(mem_rdata) : '0;

  jsrr_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (idx_q),
    .wdata_i (job_q),
    .rdata_o (mem_rdata)
  );

  // Sequencer, slot state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      steps_q     <= '0;
      last_q      <= jsrr_pkg::SLOT_W'(jsrr_pkg::SLOTS - 1);
      busy_q      <= '0;
      count_q     <= '0;
      cmd_q       <= jsrr_pkg::CMD_DISPATCH;
      job_q       <= '0;
      res_found_q <= 1'b0;
      res_acc_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // Load the result when it is done; drop it once the receiver takes it
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q       <= s_axis_tuser;
            job_q       <= s_axis_tdata[jsrr_pkg::JOB_BITS-1:0];
            steps_q     <= '0;
            res_found_q <= 1'b0;
            res_acc_q   <= 1'b0;
            if (s_axis_tuser == jsrr_pkg::CMD_SEARCH) begin
              idx_q <= next_slot(last_q);
            end else begin
              idx_q <= '0;
            end
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            if (cmd_q == jsrr_pkg::CMD_SEARCH) begin
              busy_q[idx_q] <= 1'b0;
              last_q        <= idx_q;
              count_q       <= count_q - 1'b1;
              res_found_q   <= 1'b1;
              state_q       <= ST_READ;
            end else begin
              busy_q[idx_q] <= 1'b1;
              count_q       <= count_q + 1'b1;
              res_acc_q     <= 1'b1;
              state_q       <= ST_DONE;
            end
          end else if (last_step) begin
            state_q <= ST_DONE;
          end else begin
            idx_q   <= next_slot(idx_q);
            steps_q <= steps_q + 1'b1;
          end
        end
        ST_READ: begin
          // Wait for the registered job word
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_q <= {jsrr_pkg::PEND_W'(count_q), res_acc_q, job_out, res_found_q};
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The pending count tracks the busy bits
  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == jsrr_pkg::CNT_W'($countones(busy_q)))
    else $error("pending count differs from busy slots");

  // The scan never runs past one lap of the table
  a_scan_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (steps_q <= jsrr_pkg::SLOT_W'(jsrr_pkg::SLOTS - 1)))
    else $error("slot scan overran the table");

  // A result never claims both a pickup and a dispatch
  a_one_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q[0] && out_data_q[jsrr_pkg::JOB_W + 1]))
    else $error("result marks both found and accepted");

  // A search hit frees its slot and records it as taken last
  a_pickup_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> (!busy_q[$past(idx_q)] && last_q == $past(idx_q)))
    else $error("picked slot not freed");

endmodule

// ----- hdl/jsrr_store.sv -----
// Job word memory: one port, write or registered read per cycle.
// Depends on jsrr_pkg for the slot count and job width.

module jsrr_store (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic                                 re_i,
  input  logic [jsrr_pkg::SLOT_W-1:0]          addr_i,
  input  logic [jsrr_pkg::JOB_BITS-1:0]        wdata_i,
  output logic [jsrr_pkg::JOB_BITS-1:0]        rdata_o
);

  logic [jsrr_pkg::JOB_BITS-1:0] mem_q [jsrr_pkg::SLOTS];
  logic [jsrr_pkg::JOB_BITS-1:0] rdata_q;

  // Write a job word into its slot
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Read a slot; hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
